// ----- rtl/irt_pkg.sv -----
// ----------------------------------------------------------------------------
// irt_pkg
// Shared constants and types for the interval reservation table: result
// codes, request codes, state encoding and the control word of the cell chain.
// ----------------------------------------------------------------------------
package irt_pkg;

    localparam int CAPACITY_DEF   = 64;
    localparam int COORD_BITS_DEF = 20;
    localparam int COUNT_BITS     = 7;
    localparam int ERR_BITS       = 2;

    localparam logic [ERR_BITS-1:0] ERR_OK    = 2'd0;
    localparam logic [ERR_BITS-1:0] ERR_FULL  = 2'd1;
    localparam logic [ERR_BITS-1:0] ERR_ORDER = 2'd2;

    localparam logic FUNC_ADD   = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    // token control travelling down the chain
    typedef struct packed {
        logic busy;
        logic placed;
    } cell_ctrl_t;

endpackage

// ----- rtl/irt_cell.sv -----
// ----------------------------------------------------------------------------
// irt_cell
// One table entry. Checks the passing add token for overlap, drops itself on
// a hit, takes the new interval instead if it is the first free or hit
// entry, and hands the token to the next cell in the next cycle.
// ----------------------------------------------------------------------------
module irt_cell #(
    parameter int COORD_BITS = irt_pkg::COORD_BITS_DEF,
    parameter int CNT_W      = 7
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  irt_pkg::cell_ctrl_t    tok_ctrl_in,
    input  logic [COORD_BITS-1:0]  tok_low_in,
    input  logic [COORD_BITS-1:0]  tok_high_in,
    input  logic [CNT_W-1:0]       tok_removed_in,
    output irt_pkg::cell_ctrl_t    tok_ctrl_out,
    output logic [COORD_BITS-1:0]  tok_low_out,
    output logic [COORD_BITS-1:0]  tok_high_out,
    output logic [CNT_W-1:0]       tok_removed_out
);

    logic                  valid_reg, valid_next;
    logic [COORD_BITS-1:0] low_reg, high_reg;
    irt_pkg::cell_ctrl_t   ctrl_reg, ctrl_next;
    logic [COORD_BITS-1:0] tlow_reg, thigh_reg;
    logic [CNT_W-1:0]      removed_reg, removed_next;
    logic                  hit, take;

    always_comb begin
        hit  = tok_ctrl_in.busy && valid_reg
               && !((tok_high_in < low_reg) || (high_reg < tok_low_in));
        take = tok_ctrl_in.busy && !tok_ctrl_in.placed && (!valid_reg || hit);
        valid_next = valid_reg;
        if (take) begin
            valid_next = 1'b1;
        end else if (hit) begin
            valid_next = 1'b0;
        end
        ctrl_next.busy   = tok_ctrl_in.busy;
        ctrl_next.placed = tok_ctrl_in.placed || take;
        removed_next     = hit ? tok_removed_in + CNT_W'(1) : tok_removed_in;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            ctrl_reg  <= '0;
        end else begin
            valid_reg <= valid_next;
            ctrl_reg  <= ctrl_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            low_reg  <= tok_low_in;
            high_reg <= tok_high_in;
        end
        tlow_reg    <= tok_low_in;
        thigh_reg   <= tok_high_in;
        removed_reg <= removed_next;
    end

    assign tok_ctrl_out    = ctrl_reg;
    assign tok_low_out     = tlow_reg;
    assign tok_high_out    = thigh_reg;
    assign tok_removed_out = removed_reg;

endmodule

// ----- rtl/interval_reservation_table.sv -----
// ----------------------------------------------------------------------------
// interval_reservation_table
// Set of disjoint closed intervals held in a chain of entry cells. An add
// evicts every overlapping entry and stores the new interval in the lowest
// free entry; a query returns the number of stored intervals.
//
//   channel   ports                               direction
//   request   s_valid s_ready s_func s_new_*      in
//   result    m_valid m_ready m_answer_count      out
//             m_error_code
//
// query and reversed add: result registered, valid in the cycle after acceptance
// add: result once the token has passed every cell, the token moves one cell per
// cycle down the chain; the next request can go at the edge that reads it
// reset clears every entry valid bit and the count at once, no sweep
// one request in flight; a request is taken when idle and the result
// register is empty or being read
// ----------------------------------------------------------------------------
module interval_reservation_table #(
    parameter int CAPACITY   = irt_pkg::CAPACITY_DEF,
    parameter int COORD_BITS = irt_pkg::COORD_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_func,
    input  logic [COORD_BITS-1:0]         s_new_low,
    input  logic [COORD_BITS-1:0]         s_new_high,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [irt_pkg::COUNT_BITS-1:0] m_answer_count,
    output logic [irt_pkg::ERR_BITS-1:0]  m_error_code
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    irt_pkg::cell_ctrl_t   ctrl_w    [0:CAPACITY];
    logic [COORD_BITS-1:0] low_w     [0:CAPACITY];
    logic [COORD_BITS-1:0] high_w    [0:CAPACITY];
    logic [CNT_W-1:0]      removed_w [0:CAPACITY];

    irt_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0] total_reg, total_next;
    logic m_valid_reg, m_valid_next;
    logic [irt_pkg::COUNT_BITS-1:0] answer_reg, answer_next;
    logic [irt_pkg::ERR_BITS-1:0]   error_reg, error_next;
    logic s_fire, start_add, chain_done;
    logic [CNT_W+irt_pkg::COUNT_BITS-1:0] total_ext, removed_ext;

    assign s_ready    = (state_reg == irt_pkg::ST_IDLE) && (!m_valid_reg || m_ready);
    assign s_fire     = s_valid && s_ready;
    assign start_add  = s_fire && (s_func == irt_pkg::FUNC_ADD) && (s_new_low <= s_new_high);
    assign chain_done = ctrl_w[CAPACITY].busy;

    assign ctrl_w[0].busy   = start_add;
    assign ctrl_w[0].placed = 1'b0;
    assign low_w[0]         = s_new_low;
    assign high_w[0]        = s_new_high;
    assign removed_w[0]     = '0;

    generate
        for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
            irt_cell #(
                .COORD_BITS (COORD_BITS),
                .CNT_W      (CNT_W)
            ) u_cell (
                .aclk            (aclk),
                .aresetn         (aresetn),
                .tok_ctrl_in     (ctrl_w[i]),
                .tok_low_in      (low_w[i]),
                .tok_high_in     (high_w[i]),
                .tok_removed_in  (removed_w[i]),
                .tok_ctrl_out    (ctrl_w[i+1]),
                .tok_low_out     (low_w[i+1]),
                .tok_high_out    (high_w[i+1]),
                .tok_removed_out (removed_w[i+1])
            );
        end
    endgenerate

    assign total_ext   = {{irt_pkg::COUNT_BITS{1'b0}}, total_reg};
    assign removed_ext = {{irt_pkg::COUNT_BITS{1'b0}}, removed_w[CAPACITY]};

    always_comb begin
        state_next   = state_reg;
        total_next   = total_reg;
        m_valid_next = m_valid_reg && !m_ready;
        answer_next  = answer_reg;
        error_next   = error_reg;
        unique case (state_reg)
            irt_pkg::ST_IDLE: begin
                if (s_fire) begin
                    if (s_func == irt_pkg::FUNC_QUERY) begin
                        m_valid_next = 1'b1;
                        answer_next  = total_ext[irt_pkg::COUNT_BITS-1:0];
                        error_next   = irt_pkg::ERR_OK;
                    end else if (s_new_low > s_new_high) begin
                        m_valid_next = 1'b1;
                        answer_next  = '0;
                        error_next   = irt_pkg::ERR_ORDER;
                    end else begin
                        state_next = irt_pkg::ST_RUN;
                    end
                end
            end
            irt_pkg::ST_RUN: begin
                if (chain_done) begin
                    state_next   = irt_pkg::ST_IDLE;
                    m_valid_next = 1'b1;
                    answer_next  = removed_ext[irt_pkg::COUNT_BITS-1:0];
                    error_next   = ctrl_w[CAPACITY].placed ? irt_pkg::ERR_OK
                                                           : irt_pkg::ERR_FULL;
                    total_next   = total_reg - removed_w[CAPACITY]
                                   + CNT_W'(ctrl_w[CAPACITY].placed);
                end
            end
            default: begin
                state_next = irt_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= irt_pkg::ST_IDLE;
            total_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            total_reg   <= total_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        answer_reg <= answer_next;
        error_reg  <= error_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_answer_count = answer_reg;
    assign m_error_code   = error_reg;

endmodule

// ----- rtl/irt_checker.sv -----
// ----------------------------------------------------------------------------
// irt_port_checker
// Port-level checks for the interval reservation table, bound to the top
// level.
// ----------------------------------------------------------------------------
module irt_port_checker #(
    parameter int COORD_BITS = irt_pkg::COORD_BITS_DEF
) (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_valid,
    input logic                           s_ready,
    input logic                           s_func,
    input logic [COORD_BITS-1:0]          s_new_low,
    input logic [COORD_BITS-1:0]          s_new_high,
    input logic                           m_valid,
    input logic                           m_ready,
    input logic [irt_pkg::COUNT_BITS-1:0] m_answer_count,
    input logic [irt_pkg::ERR_BITS-1:0]   m_error_code
);

    // a held result keeps its payload
    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_answer_count) && $stable(m_error_code))
        else $error("result changed while stalled");

    // an accepted add in order keeps the request side closed next cycle
    a_add_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_func == irt_pkg::FUNC_ADD) && (s_new_low <= s_new_high)
        |=> !s_ready)
        else $error("request taken while add in flight");

    // a reversed add gives its result next cycle
    a_order_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_func == irt_pkg::FUNC_ADD) && (s_new_low > s_new_high)
        |=> m_valid && (m_error_code == irt_pkg::ERR_ORDER) && (m_answer_count == '0))
        else $error("reversed add not reported");

    // a full table means nothing was evicted
    a_full_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_error_code == irt_pkg::ERR_FULL) |-> m_answer_count == '0)
        else $error("full table with evictions");

endmodule

bind interval_reservation_table irt_port_checker #(
    .COORD_BITS (COORD_BITS)
) u_irt_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .s_func         (s_func),
    .s_new_low      (s_new_low),
    .s_new_high     (s_new_high),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_answer_count (m_answer_count),
    .m_error_code   (m_error_code)
);

// ----- test/irt_checker.sv -----
// ----------------------------------------------------------------------------
// irt_checker
// Watches both channels of the interval reservation table. Keeps its own copy
// of the stored intervals, works out the answer to every accepted request and
// compares each result, field by field, with the oldest answer still due.
// ----------------------------------------------------------------------------
module irt_checker #(
    parameter int CAPACITY   = irt_pkg::CAPACITY_DEF,
    parameter int COORD_BITS = irt_pkg::COORD_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  logic                           s_func,
    input  logic [COORD_BITS-1:0]          s_new_low,
    input  logic [COORD_BITS-1:0]          s_new_high,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  logic [irt_pkg::COUNT_BITS-1:0] m_answer_count,
    input  logic [irt_pkg::ERR_BITS-1:0]   m_error_code,
    output int                             fail_count,
    output int                             pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import irt_pkg::*;

    typedef struct packed {
        logic [COUNT_BITS-1:0] count;
        logic [ERR_BITS-1:0]   err;
    } reservation_answer_t;

    logic [COORD_BITS-1:0] slot_low  [CAPACITY];
    logic [COORD_BITS-1:0] slot_high [CAPACITY];
    logic                  slot_held [CAPACITY];
    int                    held_total;
    reservation_answer_t   answers_due[$];

    function automatic reservation_answer_t reserve_interval(
        input logic                  func,
        input logic [COORD_BITS-1:0] lo,
        input logic [COORD_BITS-1:0] hi
    );
        reservation_answer_t ans;
        int removed;
        int free_slot;
        removed   = 0;
        free_slot = -1;
        if (func == FUNC_QUERY) begin
            ans.count = COUNT_BITS'(held_total);
            ans.err   = ERR_OK;
        end else if (lo > hi) begin
            ans.count = '0;
            ans.err   = ERR_ORDER;
        end else begin
            for (int i = 0; i < CAPACITY; i++) begin
                if (slot_held[i] && !(hi < slot_low[i] || slot_high[i] < lo)) begin
                    slot_held[i] = 1'b0;
                    removed++;
                end
            end
            held_total -= removed;
            for (int i = 0; i < CAPACITY; i++) begin
                if (!slot_held[i] && free_slot < 0) begin
                    free_slot = i;
                end
            end
            ans.count = COUNT_BITS'(removed);
            if (free_slot < 0) begin
                ans.err = ERR_FULL;
            end else begin
                slot_low[free_slot]  = lo;
                slot_high[free_slot] = hi;
                slot_held[free_slot] = 1'b1;
                held_total++;
                ans.err = ERR_OK;
            end
        end
        return ans;
    endfunction

    always @(posedge aclk) begin
        reservation_answer_t due;
        if (!aresetn) begin
            for (int i = 0; i < CAPACITY; i++) begin
                slot_held[i] = 1'b0;
                slot_low[i]  = '0;
                slot_high[i] = '0;
            end
            held_total = 0;
            answers_due.delete();
            fail_count = 0;
            pending    = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (answers_due.size() == 0) begin
                    $display("%0t: unexpected result count %0d error %0d",
                             $time, m_answer_count, m_error_code);
                    fail_count++;
                end else begin
                    due = answers_due.pop_front();
                    if (m_answer_count !== due.count) begin
                        $display("%0t: answer_count expected %0d actual %0d",
                                 $time, due.count, m_answer_count);
                        fail_count++;
                    end
                    if (m_error_code !== due.err) begin
                        $display("%0t: error_code expected %0d actual %0d",
                                 $time, due.err, m_error_code);
                        fail_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                answers_due.push_back(reserve_interval(s_func, s_new_low, s_new_high));
            end
            pending = answers_due.size();
        end
    end

endmodule

// ----- test/tb_interval_reservation_table.sv -----
// ----------------------------------------------------------------------------
// tb_interval_reservation_table
// Drives the interval reservation table with directed edge cases, then with
// bursts of disjoint intervals that can fill the table, mixed with overlapping,
// wide, reversed and query requests, under three idling patterns. The
// checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_interval_reservation_table;
    timeunit 1ns;
    timeprecision 1ps;

    import irt_pkg::*;

    localparam int CAPACITY     = CAPACITY_DEF;
    localparam int COORD_BITS   = COORD_BITS_DEF;
    localparam int COORD_MAX    = (1 << COORD_BITS) - 1;
    localparam int ITEM_TARGET  = 1300;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = CAPACITY + 16;

    logic                  aclk       = 1'b0;
    logic                  aresetn    = 1'b0;
    logic                  s_valid    = 1'b0;
    logic                  s_ready;
    logic                  s_func     = FUNC_QUERY;
    logic [COORD_BITS-1:0] s_new_low  = '0;
    logic [COORD_BITS-1:0] s_new_high = '0;
    logic                  m_valid;
    logic                  m_ready    = 1'b0;
    logic [COUNT_BITS-1:0] m_answer_count;
    logic [ERR_BITS-1:0]   m_error_code;

    int fail_count;
    int pending;
    int cycle_count   = 0;
    int items_sent    = 0;
    int send_idle_pct = 10;
    int recv_idle_pct = 46;
    int recent_low[$];
    int recent_high[$];

    interval_reservation_table #(
        .CAPACITY   (CAPACITY),
        .COORD_BITS (COORD_BITS)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_func         (s_func),
        .s_new_low      (s_new_low),
        .s_new_high     (s_new_high),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_answer_count (m_answer_count),
        .m_error_code   (m_error_code)
    );

    irt_checker #(
        .CAPACITY   (CAPACITY),
        .COORD_BITS (COORD_BITS)
    ) u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_func         (s_func),
        .s_new_low      (s_new_low),
        .s_new_high     (s_new_high),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_answer_count (m_answer_count),
        .m_error_code   (m_error_code),
        .fail_count     (fail_count),
        .pending        (pending)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic send_request(input logic func, input int lo, input int hi);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) begin
            gap++;
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_func     <= func;
        s_new_low  <= lo[COORD_BITS-1:0];
        s_new_high <= hi[COORD_BITS-1:0];
        do @(posedge aclk); while (!s_ready);
        items_sent++;
        if (func == FUNC_ADD && lo <= hi) begin
            recent_low.push_back(lo);
            recent_high.push_back(hi);
            if (recent_low.size() > 16) begin
                void'(recent_low.pop_front());
                void'(recent_high.pop_front());
            end
        end
    endtask

    task automatic wait_for_answers();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    // run of disjoint intervals, at times enough to fill the table
    task automatic fill_burst();
        int len;
        int stride;
        int base;
        int lo;
        len    = $urandom_range(20, 72);
        stride = 1 << $urandom_range(3, 12);
        base   = $urandom_range(0, COORD_MAX - len * stride);
        for (int k = 0; k < len; k++) begin
            lo = base + k * stride;
            send_request(FUNC_ADD, lo, lo + $urandom_range(0, stride - 1));
            if ($urandom_range(9) == 0) begin
                send_request(FUNC_QUERY, $urandom_range(0, COORD_MAX),
                             $urandom_range(0, COORD_MAX));
            end
        end
    endtask

    task automatic random_request();
        int pick;
        int lo;
        int hi;
        int idx;
        pick = $urandom_range(99);
        if (pick < 10) begin
            send_request(FUNC_QUERY, $urandom_range(0, COORD_MAX),
                         $urandom_range(0, COORD_MAX));
        end else if (pick < 20) begin
            lo = $urandom_range(1, COORD_MAX);
            send_request(FUNC_ADD, lo, $urandom_range(0, lo - 1));
        end else if (pick < 50 && recent_low.size() > 0) begin
            idx = $urandom_range(0, recent_low.size() - 1);
            lo  = recent_low[idx] + $urandom_range(0, recent_high[idx] - recent_low[idx]);
            if ($urandom_range(1) == 1 && lo > 0) begin
                lo = lo - $urandom_range(0, (lo < 64) ? lo : 64);
            end
            hi = lo + $urandom_range(0, 4 * (recent_high[idx] - recent_low[idx]) + 8);
            send_request(FUNC_ADD, lo, (hi > COORD_MAX) ? COORD_MAX : hi);
        end else if (pick < 80) begin
            lo = $urandom_range(0, COORD_MAX);
            hi = lo + $urandom_range(0, 1023);
            send_request(FUNC_ADD, lo, (hi > COORD_MAX) ? COORD_MAX : hi);
        end else begin
            lo = $urandom_range(0, COORD_MAX);
            hi = $urandom_range(0, COORD_MAX);
            if (lo > hi) begin
                send_request(FUNC_ADD, hi, lo);
            end else begin
                send_request(FUNC_ADD, lo, hi);
            end
        end
    endtask

    initial begin
        int stage;
        stage = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_request(FUNC_QUERY, 0, 0);
        send_request(FUNC_ADD, 1, 0);
        send_request(FUNC_ADD, COORD_MAX, 0);
        send_request(FUNC_ADD, 0, 0);
        send_request(FUNC_ADD, COORD_MAX, COORD_MAX);
        send_request(FUNC_QUERY, COORD_MAX, COORD_MAX);
        send_request(FUNC_ADD, 0, COORD_MAX);
        send_request(FUNC_QUERY, 'h5_5555, 'hA_AAAA);
        send_request(FUNC_ADD, 10, 20);
        send_request(FUNC_ADD, 21, 30);
        send_request(FUNC_ADD, 31, 31);
        send_request(FUNC_ADD, 20, 21);
        send_request(FUNC_ADD, 9, 9);
        send_request(FUNC_ADD, 32, 40);
        send_request(FUNC_ADD, 40, 40);
        send_request(FUNC_ADD, 8, 41);
        send_request(FUNC_QUERY, COORD_MAX, 0);
        send_request(FUNC_ADD, 'hA_AAAA, 'h5_5555);
        send_request(FUNC_ADD, 'h5_5555, 'hA_AAAA);
        send_request(FUNC_ADD, COORD_MAX - 1, COORD_MAX);
        send_request(FUNC_ADD, COORD_MAX, COORD_MAX - 1);
        send_request(FUNC_QUERY, 0, COORD_MAX);

        // hold off until the table has answered everything
        wait_for_answers();

        while (items_sent < ITEM_TARGET) begin
            if (stage == 0 && items_sent >= ITEM_TARGET / 3) begin
                wait_for_answers();
                send_idle_pct = 46;
                recv_idle_pct = 10;
                stage = 1;
            end else if (stage == 1 && items_sent >= 2 * ITEM_TARGET / 3) begin
                wait_for_answers();
                send_idle_pct = 0;
                recv_idle_pct = 0;
                stage = 2;
            end
            if ($urandom_range(99) < 6) begin
                fill_burst();
            end else begin
                random_request();
            end
        end

        wait_for_answers();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/irt_pkg.sv
rtl/irt_cell.sv
rtl/interval_reservation_table.sv
rtl/irt_checker.sv
test/irt_checker.sv
test/tb_interval_reservation_table.sv
